// File: src/ple_pkg.sv
// Shared constants and control types for the positional list engine.
`default_nettype none
package ple_pkg;

    localparam int CAPACITY = 64;
    localparam int ELEM_W   = 32;
    localparam int CMD_W    = 2;
    localparam int POS_W    = 7;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd2;

    typedef struct packed {
        logic load;
        logic start;
        logic rd_en;
        logic proc_en;
        logic put;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic legal;
        logic no_scan;
        logic is_insert;
        logic is_locate;
        logic rd_last;
        logic hit;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

// File: src/positional_list_engine.sv
// Positional list engine top level: ordered list with insert, delete and locate.
//
// Input channel (i_in_valid / o_in_stall) carries one command per transaction:
// insert at a 1-based position, delete at a position, or locate a value.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
// command: ok, removed value, found position and the list length afterwards.
// Commands are handled one at a time. Entries live in a single-port-pair RAM
// and are moved or compared one per cycle; a refused command, a locate on an
// empty list and an insert at the tail move or compare none. The longest runs
// are an insert at the head of CAPACITY - 1 entries and a locate that misses
// in a full list. Locate stops at the first match. The next command is taken
// in the cycle its predecessor's result appears.
// The result sits in an output register; the next command is accepted while
// it waits, and a further result is held back inside until it is taken.
// A stalled result holds its payload steady.
// Reset (synchronous, active low) empties the list and drops any pending
// result; RAM contents are not cleared, only entries below the count are read.
`default_nettype none
module positional_list_engine (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output      logic                      o_in_stall,
    input  wire logic [ple_pkg::CMD_W-1:0] i_command,
    input  wire logic [ple_pkg::POS_W-1:0] i_position,
    input  wire logic signed [31:0]        i_value,
    output      logic                      o_out_valid,
    input  wire logic                      i_out_stall,
    output      logic                      o_ok,
    output      logic signed [31:0]        o_removed_value,
    output      logic [6:0]                o_found_position,
    output      logic [6:0]                o_list_length
);

    ple_pkg::t_dp_cmd    dp_cmd;
    ple_pkg::t_dp_status dp_status;

    ple_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_status  (dp_status),
        .o_cmd     (dp_cmd)
    );

    ple_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_command       (i_command),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_ok            (o_ok),
        .o_removed_value (o_removed_value),
        .o_found_position(o_found_position),
        .o_list_length   (o_list_length)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("engine took a second transaction back to back");

    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_list_length <= 7'(ple_pkg::CAPACITY)))
        else $error("list length above capacity");

    a_found_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_found_position != 7'd0)) |-> o_ok)
        else $error("found position reported without ok");

    a_removed_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_removed_value != 32'sd0)) |-> o_ok)
        else $error("removed value reported without ok");

endmodule
`default_nettype wire

// File: src/ple_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: src/ple_ctrl.sv
// Controller state machine sequencing the list datapath.
`default_nettype none
module ple_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output      logic                o_in_stall,
    input  wire ple_pkg::t_dp_status i_status,
    output      ple_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.start = 1'b1;
                if (!i_status.legal) begin
                    n_state = S_FIN;
                end else if (i_status.no_scan) begin
                    n_state = i_status.is_insert ? S_PUT : S_FIN;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.proc_en = 1'b1;
                // first match ends a locate early; the stray read is ignored
                if (i_status.is_locate && i_status.hit) begin
                    n_state = S_FIN;
                end else if (i_status.rd_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.proc_en = 1'b1;
                n_state = i_status.is_insert ? S_PUT : S_FIN;
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                o_cmd.commit = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

// File: src/ple_dp.sv
// Datapath: command registers, entry RAM, scan addressing, count and result register.
`default_nettype none
module ple_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ple_pkg::t_dp_cmd           i_cmd,
    output      ple_pkg::t_dp_status        o_status,
    input  wire logic [ple_pkg::CMD_W-1:0]  i_command,
    input  wire logic [ple_pkg::POS_W-1:0]  i_position,
    input  wire logic signed [31:0]         i_value,
    output      logic                       o_out_valid,
    input  wire logic                       i_out_stall,
    output      logic                       o_ok,
    output      logic signed [31:0]         o_removed_value,
    output      logic [6:0]                 o_found_position,
    output      logic [6:0]                 o_list_length
);

    localparam int AW = ple_pkg::ADDR_W;
    localparam int CW = ple_pkg::CMP_W;

    logic [ple_pkg::CMD_W-1:0]  r_op;
    logic [ple_pkg::POS_W-1:0]  r_pos;
    logic [ple_pkg::ELEM_W-1:0] r_val;
    logic [ple_pkg::CNT_W-1:0]  r_count;
    logic [AW-1:0]              r_rd;
    logic [AW-1:0]              r_end;
    logic [AW-1:0]              r_da;
    logic                       r_dv;
    logic                       r_found;
    logic [CW-1:0]              r_fpos;
    logic [ple_pkg::ELEM_W-1:0] r_removed;

    logic [ple_pkg::ELEM_W-1:0] rd_data;
    logic                       we;
    logic [AW-1:0]              waddr;
    logic [ple_pkg::ELEM_W-1:0] wdata;

    logic [CW-1:0] pos_x;
    logic [CW-1:0] cnt_x;
    logic [AW-1:0] pidx;
    logic [AW-1:0] cnt_m1;
    logic          is_ins;
    logic          is_del;
    logic          is_loc;
    logic          legal;
    logic          proc;
    logic [AW-1:0] start_addr;
    logic [AW-1:0] end_addr;
    logic [CW-1:0] n_count;

    assign pos_x  = CW'(r_pos);
    assign cnt_x  = CW'(r_count);
    assign pidx   = AW'(pos_x - CW'(1));
    assign cnt_m1 = AW'(cnt_x - CW'(1));
    assign is_ins = (r_op == ple_pkg::CMD_INSERT);
    assign is_del = (r_op == ple_pkg::CMD_DELETE);
    assign is_loc = (r_op == ple_pkg::CMD_LOCATE);
    assign proc   = i_cmd.proc_en && r_dv;

    always_comb begin
        legal = 1'b0;
        if (is_ins) begin
            legal = (pos_x != '0) && (pos_x <= cnt_x + CW'(1))
                    && (cnt_x < CW'(ple_pkg::CAPACITY));
        end else if (is_del) begin
            legal = (pos_x != '0) && (pos_x <= cnt_x);
        end else if (is_loc) begin
            legal = 1'b1;
        end
    end

    // insert walks down from the top entry, delete and locate walk up
    always_comb begin
        if (is_ins) begin
            start_addr = cnt_m1;
            end_addr   = pidx;
        end else if (is_del) begin
            start_addr = pidx;
            end_addr   = cnt_m1;
        end else begin
            start_addr = '0;
            end_addr   = cnt_m1;
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = rd_data;
        if (i_cmd.put) begin
            we    = 1'b1;
            waddr = pidx;
            wdata = r_val;
        end else if (proc && is_ins) begin
            we    = 1'b1;
            waddr = r_da + AW'(1);
        end else if (proc && is_del && (r_da != pidx)) begin
            we    = 1'b1;
            waddr = r_da - AW'(1);
        end
    end

    ple_ram #(
        .WIDTH(ple_pkg::ELEM_W),
        .DEPTH(ple_pkg::CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(r_rd),
        .o_rdata(rd_data)
    );

    always_comb begin
        n_count = cnt_x;
        if (legal && is_ins) begin
            n_count = cnt_x + CW'(1);
        end else if (legal && is_del) begin
            n_count = cnt_x - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_command;
            r_pos     <= i_position;
            r_val     <= ple_pkg::ELEM_W'(i_value);
            r_removed <= '0;
        end
        if (i_cmd.start) begin
            r_rd  <= start_addr;
            r_end <= end_addr;
        end else if (i_cmd.rd_en) begin
            r_rd <= is_ins ? (r_rd - AW'(1)) : (r_rd + AW'(1));
        end
        r_da <= r_rd;
        if (proc && is_loc && (rd_data == r_val) && !r_found) begin
            r_fpos <= CW'(r_da) + CW'(1);
        end
        if (proc && is_del && (r_da == pidx)) begin
            r_removed <= rd_data;
        end
        if (i_cmd.commit) begin
            o_ok             <= is_loc ? r_found : legal;
            o_removed_value  <= signed'(32'(r_removed));
            o_found_position <= r_found ? r_fpos[6:0] : 7'd0;
            o_list_length    <= n_count[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dv        <= 1'b0;
            r_found     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_dv <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (proc && is_loc && (rd_data == r_val)) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_count     <= ple_pkg::CNT_W'(n_count);
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.legal     = legal;
    assign o_status.no_scan   = (is_ins && (pos_x == cnt_x + CW'(1)))
                                || (is_loc && (cnt_x == '0));
    assign o_status.is_insert = is_ins;
    assign o_status.is_locate = is_loc;
    assign o_status.rd_last   = (r_rd == r_end);
    assign o_status.hit       = r_dv && is_loc && (rd_data == r_val) && !r_found;
    assign o_status.out_free  = !o_out_valid || !i_out_stall;

endmodule
`default_nettype wire
